FILE: design/odm_pkg.sv
// Shared types, constants and the per-level qualifier update for the
// overvoltage debounce monitor. No dependencies.
package odm_pkg;

  localparam int CELL_W   = 4;
  localparam int VOLT_W   = 16;
  localparam int TICK_W   = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int MAX_LEVELS = 3;
  // Per level: 2 bits of qualifier state and one tick counter.
  localparam int LVL_W    = 2 + TICK_W;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SET_THR_L1 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SET_THR_L2 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SET_THR_L3 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REL_THR_L1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REL_THR_L2 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REL_THR_L3 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SET_TICKS  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_REL_TICKS  = 3'd7;

  typedef enum logic [1:0] {
    LS_IDLE      = 2'd0,
    LS_SETTING   = 2'd1,
    LS_SET       = 2'd2,
    LS_RELEASING = 2'd3
  } level_state_t;

  // Configuration register contents handed to the update logic.
  typedef struct packed {
    logic [MAX_LEVELS-1:0][VOLT_W-1:0] set_thr;
    logic [MAX_LEVELS-1:0][VOLT_W-1:0] rel_thr;
    logic [TICK_W-1:0]                 set_ticks;
    logic [TICK_W-1:0]                 rel_ticks;
  } cfg_regs_t;

  // Outcome of one level's update.
  typedef struct packed {
    level_state_t      st;
    logic [TICK_W-1:0] cnt;
    logic              set_ev;
    logic              rel_ev;
    logic              active;
  } level_upd_t;

  // Set check followed by release check on the state it leaves behind.
  function automatic level_upd_t level_step(
    input level_state_t      st_in,
    input logic [TICK_W-1:0] cnt_in,
    input logic [VOLT_W-1:0] volt,
    input logic [VOLT_W-1:0] set_thr,
    input logic [VOLT_W-1:0] rel_thr,
    input logic [TICK_W-1:0] set_ticks,
    input logic [TICK_W-1:0] rel_ticks
  );
    level_upd_t   r;
    level_state_t st;
    logic [TICK_W-1:0] cnt;
    st = st_in;
    cnt = cnt_in;
    r.set_ev = 1'b0;
    r.rel_ev = 1'b0;
    if (volt >= set_thr) begin
      if (st == LS_IDLE) begin
        st = LS_SETTING;
        cnt = '0;
      end else if (st == LS_SETTING) begin
        cnt = cnt + 1'b1;
        if (cnt >= set_ticks) begin
          st = LS_SET;
          r.set_ev = 1'b1;
        end
      end
    end else if (st == LS_SETTING) begin
      st = LS_IDLE;
    end
    if (volt < rel_thr) begin
      if (st == LS_SET) begin
        st = LS_RELEASING;
        cnt = '0;
      end else if (st == LS_RELEASING) begin
        cnt = cnt + 1'b1;
        if (cnt >= rel_ticks) begin
          st = LS_IDLE;
          cnt = '0;
          r.rel_ev = 1'b1;
        end
      end
    end else if (st == LS_RELEASING) begin
      st = LS_SET;
    end
    r.st = st;
    r.cnt = cnt;
    r.active = (st == LS_SET) || (st == LS_RELEASING);
    return r;
  endfunction

endpackage

FILE: design/odm_ifs.sv
// Valid/ready channel interfaces for samples, results and configuration writes.
// Depends on odm_pkg for field widths.
interface odm_sample_if;
  logic                          valid;
  logic                          ready;
  logic [odm_pkg::CELL_W-1:0]    cell_index;
  logic [odm_pkg::VOLT_W-1:0]    voltage;
  modport source (output valid, output cell_index, output voltage, input ready);
  modport sink   (input valid, input cell_index, input voltage, output ready);
endinterface

interface odm_result_if;
  logic                          valid;
  logic                          ready;
  logic [odm_pkg::CELL_W-1:0]    cell_out;
  logic [2:0]                    set_events;
  logic [2:0]                    release_events;
  logic [2:0]                    active_levels;
  modport source (output valid, output cell_out, output set_events,
                  output release_events, output active_levels, input ready);
  modport sink   (input valid, input cell_out, input set_events,
                  input release_events, input active_levels, output ready);
endinterface

interface odm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [odm_pkg::CFG_IDX_W-1:0]    index;
  logic [odm_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/overvoltage_debounce_monitor_core.sv
// Top level of the per-cell overvoltage debounce monitor.
// Depends on odm_pkg, odm_ifs, odm_ram, odm_regs and odm_update.
//
//  channel  modport  transaction carries
//  sample   sink     cell_index, voltage
//  result   source   cell_out, set_events, release_events, active_levels
//  cfg      sink     index, data (register write)
//
// One sample is taken per cycle while the result is not stalled. The row is read
// at the sample transaction; update, write-back and result register load happen
// when the update stage moves on; the result is offered from the output register.
// The single read and write port of the row memory sets the sample rate; a write
// to a cell still in flight is forwarded to the following read of the same cell.
// Reset clears per-cell valid bits at once, so there is no clearing pass.
// A stalled result holds the pipeline; while a result waits, one more sample is
// taken into an empty update stage, and then the input stalls.
module overvoltage_debounce_monitor_core #(
  parameter int CELLS  = 16,
  parameter int LEVELS = 3
) (
  input  logic          clk,
  input  logic          rst,
  odm_sample_if.sink    sample,
  odm_result_if.source  result,
  odm_cfg_if.sink       cfg
);
  import odm_pkg::*;

  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int ROW_W = LEVELS * LVL_W;
  localparam int EXT_W = 9;
  localparam logic [EXT_W-1:0] CELL_LIMIT = EXT_W'(CELLS);

  cfg_regs_t regs;

  // Update stage registers.
  logic                 s1_valid;
  logic [CELL_W-1:0]    s1_cell;
  logic [VOLT_W-1:0]    s1_voltage;
  logic                 s1_in_range;
  logic                 s1_row_valid;
  logic [AW-1:0]        s1_addr;

  // Last write-back, kept for forwarding.
  logic                 wb_valid;
  logic [AW-1:0]        wb_addr;
  logic [ROW_W-1:0]     wb_row;

  // Output register.
  logic                 res_valid;
  logic [CELL_W-1:0]    res_cell;
  logic [2:0]           res_sev;
  logic [2:0]           res_rev;
  logic [2:0]           res_act;

  logic [CELLS-1:0]     row_valid;
  logic [EXT_W-1:0]     in_cell_ext;
  logic [AW-1:0]        in_addr;
  logic                 in_range;
  logic                 sample_fire;
  logic                 s1_fire;
  logic                 ram_we;
  logic [ROW_W-1:0]     ram_rdata;
  logic [ROW_W-1:0]     row_cur;
  logic [ROW_W-1:0]     row_next;
  logic [2:0]           upd_sev;
  logic [2:0]           upd_rev;
  logic [2:0]           upd_act;

  odm_regs u_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Address decode of the incoming sample.
  assign in_cell_ext = {{(EXT_W-CELL_W){1'b0}}, sample.cell_index};
  assign in_addr     = in_cell_ext[AW-1:0];
  assign in_range    = in_cell_ext < CELL_LIMIT;

  // Handshake: the update stage moves when the output register is free or drained.
  assign s1_fire      = s1_valid && (!res_valid || result.ready);
  assign sample.ready = !s1_valid || s1_fire;
  assign sample_fire  = sample.valid && sample.ready;
  assign ram_we       = s1_fire && s1_in_range;

  odm_ram #(
    .WIDTH (ROW_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr),
    .wdata (row_next),
    .re    (sample_fire),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  // Current row: forwarded write, stored row, or the reset row for unwritten cells.
  always_comb begin
    if (wb_valid && (wb_addr == s1_addr)) begin
      row_cur = wb_row;
    end else if (s1_row_valid) begin
      row_cur = ram_rdata;
    end else begin
      row_cur = '0;
    end
  end

  odm_update #(
    .LEVELS (LEVELS)
  ) u_update (
    .row_in  (row_cur),
    .voltage (s1_voltage),
    .regs    (regs),
    .row_out (row_next),
    .set_ev  (upd_sev),
    .rel_ev  (upd_rev),
    .active  (upd_act)
  );

  // Update stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  // Update stage payload, captured with the memory read.
  always_ff @(posedge clk) begin
    if (sample_fire) begin
      s1_cell      <= sample.cell_index;
      s1_voltage   <= sample.voltage;
      s1_in_range  <= in_range;
      s1_addr      <= in_addr;
      s1_row_valid <= row_valid[in_addr];
    end
  end

  // Per-cell valid bits and the forwarding register.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      wb_valid  <= 1'b0;
    end else if (ram_we) begin
      row_valid[s1_addr] <= 1'b1;
      wb_valid           <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      wb_addr <= s1_addr;
      wb_row  <= row_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_fire) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res_cell <= s1_cell;
      res_sev  <= s1_in_range ? upd_sev : 3'b000;
      res_rev  <= s1_in_range ? upd_rev : 3'b000;
      res_act  <= s1_in_range ? upd_act : 3'b000;
    end
  end

  assign result.valid          = res_valid;
  assign result.cell_out       = res_cell;
  assign result.set_events     = res_sev;
  assign result.release_events = res_rev;
  assign result.active_levels  = res_act;

  // A level cannot both set and release in one step.
  a_no_set_and_release: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((res_sev & res_rev) == 3'b000))
    else $error("set and release event on the same level");

  // A level that just set is active afterwards.
  a_set_is_active: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((res_sev & ~res_act) == 3'b000))
    else $error("set event on an inactive level");

  // A level that just released is no longer active.
  a_release_is_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((res_rev & res_act) == 3'b000))
    else $error("release event on an active level");

  // Every update that leaves the stage shows up in the output register.
  a_update_to_result: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> res_valid)
    else $error("update lost before the output register");

  // Memory writes only happen for cells that exist.
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (({{(EXT_W-AW){1'b0}}, s1_addr}) < CELL_LIMIT))
    else $error("row write beyond the cell count");

endmodule

FILE: design/odm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module odm_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/odm_regs.sv
// Configuration register file for thresholds and tick limits.
// Depends on odm_pkg and the odm_cfg_if interface.
module odm_regs (
  input  logic               clk,
  input  logic               rst,
  odm_cfg_if.sink            cfg,
  output odm_pkg::cfg_regs_t regs
);
  import odm_pkg::*;

  // Writes are always taken.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_SET_THR_L1: regs.set_thr[0] <= cfg.data;
        REG_SET_THR_L2: regs.set_thr[1] <= cfg.data;
        REG_SET_THR_L3: regs.set_thr[2] <= cfg.data;
        REG_REL_THR_L1: regs.rel_thr[0] <= cfg.data;
        REG_REL_THR_L2: regs.rel_thr[1] <= cfg.data;
        REG_REL_THR_L3: regs.rel_thr[2] <= cfg.data;
        REG_SET_TICKS:  regs.set_ticks  <= cfg.data[TICK_W-1:0];
        REG_REL_TICKS:  regs.rel_ticks  <= cfg.data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: design/odm_update.sv
// Per-level qualifier update for one memory row (all levels of one cell).
// Depends on odm_pkg.
module odm_update #(
  parameter int LEVELS = 3
) (
  input  logic [LEVELS*odm_pkg::LVL_W-1:0] row_in,
  input  logic [odm_pkg::VOLT_W-1:0]       voltage,
  input  odm_pkg::cfg_regs_t               regs,
  output logic [LEVELS*odm_pkg::LVL_W-1:0] row_out,
  output logic [2:0]                       set_ev,
  output logic [2:0]                       rel_ev,
  output logic [2:0]                       active
);
  import odm_pkg::*;

  level_upd_t upd [LEVELS];

  // One lane per level; lanes are independent.
  for (genvar l = 0; l < LEVELS; l++) begin : g_lane
    always_comb begin
      upd[l] = level_step(level_state_t'(row_in[l*LVL_W + TICK_W +: 2]),
                          row_in[l*LVL_W +: TICK_W], voltage,
                          regs.set_thr[l], regs.rel_thr[l],
                          regs.set_ticks, regs.rel_ticks);
    end
    assign row_out[l*LVL_W + TICK_W +: 2] = upd[l].st;
    assign row_out[l*LVL_W +: TICK_W]     = upd[l].cnt;
    assign set_ev[l] = upd[l].set_ev;
    assign rel_ev[l] = upd[l].rel_ev;
    assign active[l] = upd[l].active;
  end

  // Levels beyond the configured count report nothing.
  for (genvar u = LEVELS; u < MAX_LEVELS; u++) begin : g_unused
    assign set_ev[u] = 1'b0;
    assign rel_ev[u] = 1'b0;
    assign active[u] = 1'b0;
  end

endmodule
